// ===== rtl/hdng_pkg.sv =====
// ----------------------------------------------------------------------------
// hdng_pkg
// Shared constants, command codes and control types of the n-gram encoder.
// ----------------------------------------------------------------------------
package hdng_pkg;

   localparam int DIM_DEF      = 1024;
   localparam int NGRAM_DEF    = 3;
   localparam int SUM_BITS_DEF = 22;

   localparam int LANES     = 64;
   localparam int NSYM      = 27;
   localparam int SUM_OUT_W = 22;

   localparam logic [4:0] SYM_SPACE = 5'd26;
   localparam logic [7:0] CHAR_A    = 8'h61;
   localparam logic [7:0] CHAR_Z    = 8'h7a;
   localparam logic [7:0] CHAR_SP   = 8'h20;

   typedef enum logic [2:0] {
      FUNC_LOAD    = 3'd0,
      FUNC_CLEAR   = 3'd1,
      FUNC_CHAR    = 3'd2,
      FUNC_RD_SUM  = 3'd3,
      FUNC_RD_SIGN = 3'd4
   } func_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic known;
      logic wr_en;
      logic rd_start;
      logic rd_adv;
   } hist_ctrl_type;

endpackage

// ===== rtl/hdng_ram.sv =====
// ----------------------------------------------------------------------------
// hdng_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hdng_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/hdng_hist.sv =====
// ----------------------------------------------------------------------------
// hdng_hist
// History rows: one word RAM per row, a circular row pointer, a rotation
// count per row, and word-serial funnel readout of the bound product.
// ----------------------------------------------------------------------------
module hdng_hist import hdng_pkg::*; #(
   parameter int DIM   = DIM_DEF,
   parameter int NGRAM = NGRAM_DEF,
   parameter int WORDS = DIM / LANES,
   parameter int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  hist_ctrl_type     ctrl,
   input  logic [WAW-1:0]    wr_word,
   input  logic [LANES-1:0]  wr_data,
   output logic [LANES-1:0]  prod,
   output logic              all_valid
);

   localparam int RW = (NGRAM > 1) ? $clog2(NGRAM) : 1;
   localparam int SW = $clog2(LANES);

   logic [RW-1:0]    base_ff;
   logic [RW-1:0]    base_dec;
   logic [NGRAM-1:0] valid_ff;
   logic [WAW-1:0]   q_ff    [NGRAM];
   logic [SW-1:0]    s_ff    [NGRAM];
   logic [WAW-1:0]   addr_ff [NGRAM];
   logic [LANES-1:0] prev_ff [NGRAM];
   logic [LANES-1:0] ram_q   [NGRAM];
   logic [LANES-1:0] rowc    [NGRAM];

   assign base_dec  = (base_ff == '0) ? RW'(NGRAM - 1) : base_ff - 1'b1;
   assign all_valid = &valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         valid_ff <= '0;
      end else if (ctrl.clear) begin
         valid_ff <= '0;
      end else if (ctrl.step) begin
         base_ff <= base_dec;
         if (ctrl.known) begin
            valid_ff[base_dec] <= 1'b1;
         end
      end
   end

   for (genvar p = 0; p < NGRAM; p++) begin : g_row
      logic [SW:0]        sh;
      logic [2*LANES-1:0] cat_sh;

      always_ff @(posedge clock) begin
         if (ctrl.step) begin
            if (ctrl.known && base_dec == RW'(p)) begin
               q_ff[p] <= '0;
               s_ff[p] <= '0;
            end else begin
               s_ff[p] <= s_ff[p] + 1'b1;
               if (s_ff[p] == SW'(LANES - 1)) begin
                  q_ff[p] <= (q_ff[p] == WAW'(WORDS - 1)) ? '0 : q_ff[p] + 1'b1;
               end
            end
         end
         if (ctrl.rd_start) begin
            addr_ff[p] <= WAW'(WORDS - 1) - q_ff[p];
         end else if (ctrl.rd_adv) begin
            addr_ff[p] <= (addr_ff[p] == WAW'(WORDS - 1)) ? '0 : addr_ff[p] + 1'b1;
         end
         prev_ff[p] <= ram_q[p];
      end

      hdng_ram #(
         .WIDTH (LANES),
         .DEPTH (WORDS)
      ) u_row (
         .clock   (clock),
         .wr_en   (ctrl.wr_en && base_ff == RW'(p)),
         .wr_addr (wr_word),
         .wr_data (wr_data),
         .rd_addr (addr_ff[p]),
         .rd_data (ram_q[p])
      );

      // lo word holds elements before the chunk, hi word the chunk itself
      assign sh      = (SW + 1)'(LANES) - {1'b0, s_ff[p]};
      assign cat_sh  = {ram_q[p], prev_ff[p]} >> sh;
      assign rowc[p] = cat_sh[LANES-1:0];
   end

   // bipolar product: +1 when the count of -1 elements is even
   always_comb begin
      logic [LANES-1:0] z;
      z = '0;
      for (int p = 0; p < NGRAM; p++) begin
         z = z ^ ~rowc[p];
      end
      prod = ~z;
   end

endmodule

// ===== rtl/hd_ngram_text_encoder.sv =====
// ----------------------------------------------------------------------------
// hd_ngram_text_encoder
// Hyperdimensional n-gram text encoder with chunk-serial history and counters.
// ----------------------------------------------------------------------------
// Usage: one req_ item carries a command in req_func: load a 64-element
// chunk of a symbol's item vector, clear, encode one text byte, read one
// counter, or read 64 sign bits. Every item returns exactly one rsp_ item
// with the counter value, the sign chunk and the sticky overflow flag.
// Timing: the item memory, the history rows and the counters are RAMs of
// 64-element words, walked one word per cycle. A letter or space copies its
// item vector into the history word by word; then, once NGRAM characters
// have been seen, a character runs the counter read-modify-write pass over
// all words. One item is in work at a time; req_stall is high while it runs.
// The result sits in an output register, so a new item is accepted while
// rsp_stall holds the previous result; the next result waits until that
// register is free. Reset (synchronous) and clear drop history, counters
// and the flag at once through per-row valid bits; the item memory keeps
// its contents until loaded again. DIM is a multiple of 64.
// ----------------------------------------------------------------------------
module hd_ngram_text_encoder import hdng_pkg::*; #(
   parameter int DIM      = DIM_DEF,
   parameter int NGRAM    = NGRAM_DEF,
   parameter int SUM_BITS = SUM_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_func,
   input  logic [4:0]                  req_symbol_index,
   input  logic [3:0]                  req_chunk_index,
   input  logic [63:0]                 req_item_bits,
   input  logic [7:0]                  req_char_code,
   input  logic [9:0]                  req_element_index,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SUM_OUT_W-1:0] rsp_sum_value,
   output logic [63:0]                 rsp_sign_bits,
   output logic                        rsp_overflow
);

   localparam int WORDS  = DIM / LANES;
   localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IDEPTH = NSYM * WORDS;
   localparam int IAW    = $clog2(IDEPTH);
   localparam int CW     = $clog2(WORDS + 2);
   localparam int SEW    = $clog2(NGRAM + 1);
   localparam int LW     = $clog2(LANES);
   localparam logic signed [SUM_BITS-1:0] SMAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SMIN = -SMAX;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_COPY = 6'b000010,
      ST_PREP = 6'b000100,
      ST_ACC  = 6'b001000,
      ST_RD   = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic                      req_take;
   logic                      sym_known;
   logic [4:0]                sym_code;
   logic [CW-1:0]             cnt_ff;
   logic [SEW-1:0]            seen_ff;
   logic                      acc_ff;
   logic                      ovf_ff;
   logic                      sat_any;
   logic [IAW-1:0]            ibase_ff;
   logic [IAW-1:0]            irow_addr;
   logic [IAW-1:0]            iwr_addr;
   logic                      iwr_en;
   logic [LANES-1:0]          iq;
   hist_ctrl_type             hctrl;
   logic [LANES-1:0]          prod;
   logic                      all_valid;
   logic [WORDS-1:0]          cvalid_ff;
   logic [WAW-1:0]            crd_addr;
   logic [WAW-1:0]            cwr_addr;
   logic                      cwr_en;
   logic [LANES*SUM_BITS-1:0] cq;
   logic [LANES*SUM_BITS-1:0] cwr_data;
   logic                      rd_sign_ff;
   logic                      rd_ok_ff;
   logic [LW-1:0]             lane_ff;
   logic [WAW-1:0]            rd_row_ff;
   logic [WAW-1:0]            req_row;
   logic                      elem_ok;
   logic                      chunk_ok;
   logic signed [SUM_OUT_W-1:0] res_sum_ff;
   logic [63:0]               res_sign_ff;
   logic signed [SUM_BITS-1:0] lane_val;
   logic signed [31:0]        lane_ext;
   logic                      rsp_free;
   logic                      rsp_valid_ff;
   logic signed [SUM_OUT_W-1:0] rsp_sum_ff;
   logic [63:0]               rsp_sign_ff;
   logic                      rsp_ovf_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      sym_known = 1'b0;
      sym_code  = SYM_SPACE;
      if (req_char_code >= CHAR_A && req_char_code <= CHAR_Z) begin
         sym_known = 1'b1;
         sym_code  = 5'(req_char_code - CHAR_A);
      end else if (req_char_code == CHAR_SP) begin
         sym_known = 1'b1;
      end
   end

   assign elem_ok  = 32'(req_element_index) < 32'(DIM);
   assign chunk_ok = 32'(req_chunk_index) < 32'(WORDS);
   assign req_row  = WAW'(req_element_index >> LW);

   // item memory
   assign iwr_en   = req_take && req_func == FUNC_LOAD && req_symbol_index <= SYM_SPACE
                     && chunk_ok;
   assign iwr_addr = IAW'(int'(req_symbol_index) * WORDS + int'(req_chunk_index));
   assign irow_addr = ibase_ff + ((cnt_ff < CW'(WORDS)) ? IAW'(cnt_ff) : '0);

   hdng_ram #(
      .WIDTH (LANES),
      .DEPTH (IDEPTH)
   ) u_item (
      .clock   (clock),
      .wr_en   (iwr_en),
      .wr_addr (iwr_addr),
      .wr_data (req_item_bits),
      .rd_addr (irow_addr),
      .rd_data (iq)
   );

   // history
   always_comb begin
      hctrl          = '0;
      hctrl.clear    = req_take && req_func == FUNC_CLEAR;
      hctrl.step     = req_take && req_func == FUNC_CHAR;
      hctrl.known    = sym_known;
      hctrl.wr_en    = (state_ff == ST_COPY) && cnt_ff != '0;
      hctrl.rd_start = (state_ff == ST_PREP);
      hctrl.rd_adv   = (state_ff == ST_ACC);
   end

   hdng_hist #(
      .DIM   (DIM),
      .NGRAM (NGRAM)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (hctrl),
      .wr_word   (WAW'(cnt_ff - 1'b1)),
      .wr_data   (iq),
      .prod      (prod),
      .all_valid (all_valid)
   );

   // counters
   always_comb begin
      crd_addr = '0;
      if (state_ff == ST_IDLE) begin
         if (req_func == FUNC_RD_SUM) begin
            crd_addr = elem_ok ? req_row : '0;
         end else begin
            crd_addr = chunk_ok ? WAW'(req_chunk_index) : '0;
         end
      end else if (cnt_ff != '0 && cnt_ff <= CW'(WORDS)) begin
         crd_addr = WAW'(cnt_ff - 1'b1);
      end
   end

   assign cwr_en   = (state_ff == ST_ACC) && cnt_ff >= CW'(2);
   assign cwr_addr = WAW'(cnt_ff - CW'(2));

   always_comb begin
      logic signed [SUM_BITS-1:0] old_v;
      sat_any  = 1'b0;
      cwr_data = '0;
      for (int k = 0; k < LANES; k++) begin
         old_v = cvalid_ff[cwr_addr] ? cq[k*SUM_BITS +: SUM_BITS] : '0;
         if (prod[k] && old_v == SMAX) begin
            cwr_data[k*SUM_BITS +: SUM_BITS] = SMAX;
            sat_any = 1'b1;
         end else if (!prod[k] && old_v == SMIN) begin
            cwr_data[k*SUM_BITS +: SUM_BITS] = SMIN;
            sat_any = 1'b1;
         end else if (prod[k]) begin
            cwr_data[k*SUM_BITS +: SUM_BITS] = old_v + 1'b1;
         end else begin
            cwr_data[k*SUM_BITS +: SUM_BITS] = old_v - 1'b1;
         end
      end
   end

   hdng_ram #(
      .WIDTH (LANES * SUM_BITS),
      .DEPTH (WORDS)
   ) u_cnt (
      .clock   (clock),
      .wr_en   (cwr_en),
      .wr_addr (cwr_addr),
      .wr_data (cwr_data),
      .rd_addr (crd_addr),
      .rd_data (cq)
   );

   // read result
   assign lane_val = cvalid_ff[rd_row_ff] ? cq[lane_ff*SUM_BITS +: SUM_BITS] : '0;
   assign lane_ext = 32'(lane_val);

   // control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               priority if (req_func == FUNC_CHAR && sym_known) begin
                  state_in = ST_COPY;
               end else if (req_func == FUNC_CHAR && seen_ff == SEW'(NGRAM)) begin
                  state_in = ST_PREP;
               end else if (req_func == FUNC_RD_SUM || req_func == FUNC_RD_SIGN) begin
                  state_in = ST_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_COPY: begin
            if (cnt_ff == CW'(WORDS)) begin
               state_in = acc_ff ? ST_PREP : ST_DONE;
            end
         end
         ST_PREP: state_in = all_valid ? ST_ACC : ST_DONE;
         ST_ACC: begin
            if (cnt_ff == CW'(WORDS + 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_RD:   state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         seen_ff   <= '0;
         ovf_ff    <= 1'b0;
         cvalid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (req_take && req_func == FUNC_CLEAR) begin
            seen_ff   <= '0;
            ovf_ff    <= 1'b0;
            cvalid_ff <= '0;
         end
         if (req_take && req_func == FUNC_CHAR && seen_ff != SEW'(NGRAM)) begin
            seen_ff <= seen_ff + 1'b1;
         end
         if (cwr_en) begin
            cvalid_ff[cwr_addr] <= 1'b1;
            if (sat_any) begin
               ovf_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff != ST_COPY && state_ff != ST_ACC) begin
         cnt_ff <= '0;
      end else if (state_ff != state_in) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (req_take) begin
         ibase_ff    <= IAW'(int'(sym_code) * WORDS);
         acc_ff      <= (seen_ff == SEW'(NGRAM));
         rd_sign_ff  <= (req_func == FUNC_RD_SIGN);
         rd_ok_ff    <= (req_func == FUNC_RD_SIGN) ? chunk_ok : elem_ok;
         lane_ff     <= req_element_index[LW-1:0];
         rd_row_ff   <= crd_addr;
         res_sum_ff  <= '0;
         res_sign_ff <= '0;
      end
      if (state_ff == ST_RD && rd_ok_ff) begin
         if (rd_sign_ff) begin
            for (int k = 0; k < LANES; k++) begin
               res_sign_ff[k] <= cvalid_ff[rd_row_ff]
                                 && !cq[k*SUM_BITS + SUM_BITS - 1]
                                 && cq[k*SUM_BITS +: SUM_BITS] != '0;
            end
         end else begin
            res_sum_ff <= lane_ext[SUM_OUT_W-1:0];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_sum_ff  <= res_sum_ff;
         rsp_sign_ff <= res_sign_ff;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum_value = rsp_sum_ff;
   assign rsp_sign_bits = rsp_sign_ff;
   assign rsp_overflow  = rsp_ovf_ff;

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff && !(req_take && req_func == FUNC_CLEAR) |=> ovf_ff)
      else $error("overflow flag dropped without clear");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEW'(NGRAM))
      else $error("character count beyond n-gram size");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && rsp_valid_ff && rsp_stall |=> state_ff == ST_DONE)
      else $error("result left while output register busy");

   a_known_copy: assert property (@(posedge clock) disable iff (reset)
      req_take && req_func == FUNC_CHAR && sym_known |=> state_ff == ST_COPY)
      else $error("known character did not start copy");

endmodule
